/* sv/imhq_pkg.sv */
// ============================================================================
// imhq_pkg
// Shared types and constants of the indexed min-heap priority queue.
// ============================================================================
package imhq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int ID_W         = 6;
    localparam int IKEY_W       = 32;
    localparam int OP_W         = 2;
    localparam int STAT_W       = 3;
    localparam int OCC_W        = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DECREASE = 2'd1,
        OP_EXTRACT  = 2'd2,
        OP_QUERY    = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_ABSENT      = 3'd2,
        ST_NOT_SMALLER = 3'd3,
        ST_FULL        = 3'd4,
        ST_PRESENT     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_KEY,
        S_DECIDE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_RD,
        S_EX_MOVE,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

/* sv/imhq_if.sv */
// ============================================================================
// imhq_if
// Valid/ready channel that carries one payload per transaction.
// ============================================================================
interface imhq_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/indexed_min_heap_queue_top.sv */
// ============================================================================
// indexed_min_heap_queue_top
// Indexed binary min-heap with an item-to-slot position map.
// ============================================================================
//  channel   dir  payload
//  i_req     in   opcode, item_id, new_key
//  o_rsp     out  status, out_id, out_key, is_member, is_empty, occupancy
//
//  One transaction at a time: lookup, key read and checks run in turn, and the
//  response is registered after them. A sift-up level reads the parent, then
//  compares; an extract reads the last slot and moves it to the root, then each
//  sift-down level reads both children and compares, and a left-child check that
//  finds none ends it. After reset a clearing pass marks every map entry absent.
//  The response waits in an output register; the next request enters once taken.
module indexed_min_heap_queue_top #(
    parameter int CAPACITY = imhq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    imhq_if.sink   i_req,
    imhq_if.source o_rsp
);
    import imhq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef logic [KEY_BITS-1:0] t_key;

    // Heap storage and position map; the map holds CAPACITY for absent.
    logic [ID_W-1:0] r_ids  [CAPACITY];
    t_key            r_keys [CAPACITY];
    logic [CW-1:0]   r_pos  [CAPACITY];

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_clr;
    logic          r_clearing;

    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id;
    t_key              r_key;
    logic [CW-1:0]     r_slot;        // position read from the map
    logic [AW-1:0]     r_cur;         // slot being sifted
    logic [ID_W-1:0]   r_cur_id;
    t_key              r_cur_key;
    logic [AW-1:0]     r_oth;         // parent or best child
    logic [ID_W-1:0]   r_oth_id;
    t_key              r_oth_key;
    logic              r_has_oth;

    // Registered read port of the heap arrays.
    logic [AW-1:0]     w_raddr;
    logic [ID_W-1:0]   r_rd_id;
    t_key              r_rd_key;

    t_status           r_status;
    logic [ID_W-1:0]   r_oid;
    t_key              r_okey;
    logic              r_member;
    logic              r_out_valid;

    logic w_acc;
    logic w_valid_id;
    logic w_present;
    logic w_less;       // shared comparator
    t_key w_cmp_a, w_cmp_b;
    logic [AW:0] w_lchild;

    assign i_req.ready = (r_state == S_IDLE) && !r_clearing && !r_out_valid;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_valid_id  = ({{(32-ID_W){1'b0}}, r_id} < 32'(CAPACITY));
    assign w_present   = w_valid_id && (r_slot < r_count);
    assign w_less      = $signed(w_cmp_a) < $signed(w_cmp_b);
    assign w_lchild    = {r_cur, 1'b1};

    always_comb begin
        w_cmp_a = r_cur_key;
        w_cmp_b = r_rd_key;
        unique case (r_state)
            S_DECIDE: begin
                w_cmp_a = r_key;
                w_cmp_b = r_rd_key;
            end
            S_UP_CMP: begin
                w_cmp_a = r_cur_key;
                w_cmp_b = r_rd_key;
            end
            S_DN_RDR: begin
                w_cmp_a = r_rd_key;
                w_cmp_b = r_cur_key;
            end
            S_DN_CMP: begin
                w_cmp_a = r_rd_key;
                w_cmp_b = r_has_oth ? r_oth_key : r_cur_key;
            end
            default: begin
                w_cmp_a = r_cur_key;
                w_cmp_b = r_rd_key;
            end
        endcase
    end

    // Read address of the heap arrays, one read per cycle.
    always_comb begin
        w_raddr = '0;
        unique case (r_state)
            S_KEY:    w_raddr = r_slot[AW-1:0];
            S_UP_RD:  w_raddr = AW'((r_cur - 1'b1) >> 1);
            S_EX_RD:  w_raddr = AW'(r_count - 1'b1);
            S_DN_RDL: w_raddr = w_lchild[AW-1:0];
            S_DN_RDR: w_raddr = AW'(w_lchild + 1'b1);
            default:  w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_id  <= r_ids[w_raddr];
        r_rd_key <= r_keys[w_raddr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_acc) n_state = S_LOOK;
            S_LOOK:   n_state = S_KEY;
            S_KEY:    n_state = S_DECIDE;
            S_DECIDE: begin
                n_state = S_DONE;
                case (r_op)
                    OP_INSERT:
                        if (w_valid_id && !w_present && r_count < CW'(CAPACITY))
                            n_state = (r_count != '0) ? S_UP_RD : S_DONE;
                    OP_DECREASE:
                        if (w_present && w_less)
                            n_state = (r_slot != '0) ? S_UP_RD : S_DONE;
                    OP_EXTRACT:
                        if (r_count != '0) n_state = S_EX_RD;
                    default: n_state = S_DONE;
                endcase
            end
            S_UP_RD:  n_state = S_UP_CMP;
            S_UP_CMP: begin
                if (w_less && (r_cur - 1'b1) >> 1 != '0) n_state = S_UP_RD;
                else                                     n_state = S_DONE;
            end
            S_EX_RD:  n_state = S_EX_MOVE;
            S_EX_MOVE: n_state = S_DN_RDL;
            S_DN_RDL: begin
                if ({1'b0, w_lchild} < (AW+1)'(r_count)) n_state = S_DN_RDR;
                else                                      n_state = S_DONE;
            end
            S_DN_RDR: n_state = S_DN_CMP;
            S_DN_CMP: n_state = S_DN_RDL;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer datapath: storage writes and working registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    r_op  <= i_req.data.opcode;
                    r_id  <= i_req.data.item_id;
                    r_key <= KEY_BITS'($signed(i_req.data.new_key));
                end
            end
            S_LOOK: ;
            S_DECIDE: begin
                r_status <= ST_OK;
                r_oid    <= '0;
                r_okey   <= '0;
                r_member <= 1'b0;
                case (r_op)
                    OP_INSERT: begin
                        if (!w_valid_id) r_status <= ST_ABSENT;
                        else if (w_present) r_status <= ST_PRESENT;
                        else if (r_count >= CW'(CAPACITY)) r_status <= ST_FULL;
                        else begin
                            r_ids[r_count[AW-1:0]]  <= r_id;
                            r_keys[r_count[AW-1:0]] <= r_key;
                            r_pos[AW'(r_id)]        <= r_count;
                            r_cur     <= r_count[AW-1:0];
                            r_cur_id  <= r_id;
                            r_cur_key <= r_key;
                        end
                    end
                    OP_DECREASE: begin
                        if (!w_present) r_status <= ST_ABSENT;
                        else if (!w_less) r_status <= ST_NOT_SMALLER;
                        else begin
                            r_keys[r_slot[AW-1:0]] <= r_key;
                            r_cur     <= r_slot[AW-1:0];
                            r_cur_id  <= r_id;
                            r_cur_key <= r_key;
                        end
                    end
                    OP_EXTRACT: begin
                        if (r_count == '0) r_status <= ST_EMPTY;
                    end
                    default: r_member <= w_present;
                endcase
            end
            S_UP_RD: ;
            S_UP_CMP: begin
                if (w_less) begin
                    // Swap with the parent.
                    r_ids[AW'((r_cur - 1'b1) >> 1)]  <= r_cur_id;
                    r_keys[AW'((r_cur - 1'b1) >> 1)] <= r_cur_key;
                    r_ids[r_cur]  <= r_rd_id;
                    r_keys[r_cur] <= r_rd_key;
                    r_pos[AW'(r_rd_id)]  <= CW'(r_cur);
                    r_pos[AW'(r_cur_id)] <= CW'((r_cur - 1'b1) >> 1);
                    r_cur <= AW'((r_cur - 1'b1) >> 1);
                end
            end
            S_EX_RD: begin
                // Root is on the read port now.
            end
            S_EX_MOVE: ;
            S_DN_RDL: ;
            S_DN_RDR: begin
                r_has_oth <= w_less;
                r_oth     <= w_lchild[AW-1:0];
                r_oth_id  <= r_rd_id;
                r_oth_key <= r_rd_key;
            end
            S_DN_CMP: ;
            default: ;
        endcase

        // Extraction and sift-down need a few extra transfers.
        if (r_state == S_EX_RD) begin
            r_oid  <= r_ids[0];
            r_okey <= r_keys[0];
        end
        if (r_state == S_EX_MOVE) begin
            r_pos[AW'(r_oid)] <= CW'(CAPACITY);
            r_cur     <= '0;
            r_cur_id  <= r_rd_id;
            r_cur_key <= r_rd_key;
            if (r_count != CW'(1)) begin
                r_ids[0]  <= r_rd_id;
                r_keys[0] <= r_rd_key;
                r_pos[AW'(r_rd_id)] <= '0;
            end
        end
        if (r_state == S_DN_RDL && !({1'b0, w_lchild} < (AW+1)'(r_count)))
            r_has_oth <= 1'b0;
        if (r_state == S_DN_CMP) begin
            // Right child exists if its index is below the count.
            if ((AW+1)'(w_lchild + 1'b1) < (AW+1)'(r_count) && w_less) begin
                r_ids[AW'(w_lchild + 1'b1)]  <= r_cur_id;
                r_keys[AW'(w_lchild + 1'b1)] <= r_cur_key;
                r_ids[r_cur]  <= r_rd_id;
                r_keys[r_cur] <= r_rd_key;
                r_pos[AW'(r_rd_id)]  <= CW'(r_cur);
                r_pos[AW'(r_cur_id)] <= CW'(AW'(w_lchild + 1'b1));
                r_cur <= AW'(w_lchild + 1'b1);
            end else if (r_has_oth) begin
                r_ids[r_oth]  <= r_cur_id;
                r_keys[r_oth] <= r_cur_key;
                r_ids[r_cur]  <= r_oth_id;
                r_keys[r_cur] <= r_oth_key;
                r_pos[AW'(r_oth_id)] <= CW'(r_cur);
                r_pos[AW'(r_cur_id)] <= CW'(r_oth);
                r_cur <= r_oth;
            end
        end
        if (r_state == S_LOOK && w_valid_id)
            r_slot <= r_pos[AW'(r_id)];
        else if (r_state == S_LOOK)
            r_slot <= CW'(CAPACITY);
        if (r_clearing)
            r_pos[r_clr[AW-1:0]] <= CW'(CAPACITY);
    end

    // Sift-down stops when no swap happened in the compare step.
    logic w_dn_stop;
    assign w_dn_stop = !(((AW+1)'(w_lchild + 1'b1) < (AW+1)'(r_count) && w_less)
                         || r_has_oth);

    always_comb begin
        n_count = r_count;
        if (r_state == S_DECIDE && r_op == OP_INSERT && w_valid_id && !w_present
            && r_count < CW'(CAPACITY))
            n_count = r_count + 1'b1;
        if (r_state == S_EX_MOVE)
            n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_clr       <= '0;
            r_clearing  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= (r_state == S_DN_CMP && w_dn_stop) ? S_DONE : n_state;
            r_count <= n_count;
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == CW'(CAPACITY - 1)) r_clearing <= 1'b0;
            end
            if (r_state == S_DONE)               r_out_valid <= 1'b1;
            else if (o_rsp.valid && o_rsp.ready) r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_rsp.valid          = r_out_valid;
        o_rsp.data.status    = r_status;
        o_rsp.data.out_id    = r_oid;
        o_rsp.data.out_key   = IKEY_W'($signed(r_okey));
        o_rsp.data.is_member = r_member;
        o_rsp.data.is_empty  = (r_count == '0);
        o_rsp.data.occupancy = OCC_W'(r_count);
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("heap count beyond capacity");
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_req.ready)
        else $error("request taken during clearing pass");
    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_out_valid)
        else $error("finished transaction not presented");
`endif

endmodule
